/* rtl/srtf_pkg.sv */
// Shared types and operation codes for the SRTF scheduler.
package srtf_pkg;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_TICK  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [15:0] TIME_MAX = 16'hFFFF;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // Best job seen so far as the scan moves down the chain.
   typedef struct packed {
      logic        found;
      logic [15:0] remaining;
      logic [7:0]  id;
      logic [15:0] arrival;
      logic [15:0] burst;
   } cand_type;

   // Job written into a slot by a load.
   typedef struct packed {
      logic [7:0]  id;
      logic [15:0] arrival;
      logic [15:0] burst;
   } job_type;

endpackage

/* rtl/srtf_cell.sv */
// One job slot of the scheduler chain: holds the job and passes on the best candidate.
module srtf_cell #(
   parameter int IDX_W = 4
) (
   input  logic                 clock,
   input  logic [IDX_W-1:0]     slot_idx,
   input  logic                 active,
   input  logic [15:0]          cur_time,
   input  logic                 wr_en,
   input  srtf_pkg::job_type    wr_job,
   input  logic                 dec_en,
   input  srtf_pkg::cand_type   cand_in,
   input  logic [IDX_W-1:0]     idx_in,
   output srtf_pkg::cand_type   cand_out,
   output logic [IDX_W-1:0]     idx_out
);

   logic [7:0]         id_ff;
   logic [15:0]        arrival_ff;
   logic [15:0]        burst_ff;
   logic [15:0]        remaining_ff;
   logic               finished_ff;
   srtf_pkg::cand_type cand_ff;
   srtf_pkg::cand_type cand_pass_in;
   logic [IDX_W-1:0]   idx_ff;
   logic [IDX_W-1:0]   idx_pass_in;
   logic               eligible;
   logic               take;

   assign eligible = active && !finished_ff && (arrival_ff <= cur_time);
   assign take     = eligible && (!cand_in.found || (remaining_ff < cand_in.remaining));

   always_comb begin
      cand_pass_in = cand_in;
      idx_pass_in  = idx_in;
      if (take) begin
         cand_pass_in.found     = 1'b1;
         cand_pass_in.remaining = remaining_ff;
         cand_pass_in.id        = id_ff;
         cand_pass_in.arrival   = arrival_ff;
         cand_pass_in.burst     = burst_ff;
         idx_pass_in            = slot_idx;
      end
   end

   // Slot contents: written by a load, worn down by the ticks that run it.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         id_ff        <= wr_job.id;
         arrival_ff   <= wr_job.arrival;
         burst_ff     <= wr_job.burst;
         remaining_ff <= wr_job.burst;
         finished_ff  <= 1'b0;
      end else if (dec_en) begin
         remaining_ff <= remaining_ff - 16'd1;
         if (remaining_ff == 16'd1) begin
            finished_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cand_ff <= cand_pass_in;
      idx_ff  <= idx_pass_in;
   end

   assign cand_out = cand_ff;
   assign idx_out  = idx_ff;

endmodule

/* rtl/srtf_scheduler_core.sv */
// Top level of the shortest-remaining-time-first scheduler with its slot chain.
//
// Jobs live in a chain of MAX_JOBS identical cells, one job per cell. A load
// transaction writes the next free cell. A tick transaction sends an empty
// candidate down the chain, one cell per clock, each cell replacing it with
// its own job when that job has arrived, is unfinished and has strictly less
// remaining time, so ties go to the lower slot. Once the winner leaves the
// last cell, a finish step decrements it, advances the saturating time counter
// and, if the job is done, loads the result register; a finish step that
// completes a job waits while an earlier result is still held on the rsp side.
// Input stays stalled while a tick is in the chain and in its finish step, so
// a new tick is not accepted before the last one is done. Clear keeps the
// current time.
module srtf_scheduler_core #(
   parameter int MAX_JOBS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_job_id,
   input  logic [15:0] req_arrival_time,
   input  logic [15:0] req_burst_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_finished_id,
   output logic [15:0] rsp_completion_time,
   output logic [15:0] rsp_turnaround,
   output logic [15:0] rsp_waiting,
   output logic        rsp_all_done
);

   localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int CNT_W = $clog2(MAX_JOBS + 1);

   // Control state
   srtf_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0]    cnt_ff, cnt_in;
   logic [CNT_W-1:0]    job_count_ff, job_count_in;
   logic [CNT_W-1:0]    done_count_ff, done_count_in;
   logic [15:0]         time_ff, time_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Result payload
   logic [7:0]          rsp_id_ff;
   logic [15:0]         rsp_completion_ff;
   logic [15:0]         rsp_turnaround_ff;
   logic [15:0]         rsp_waiting_ff;
   logic                rsp_all_done_ff;

   // Chain wiring
   srtf_pkg::cand_type  cand_chain [MAX_JOBS+1];
   logic [IDX_W-1:0]    idx_chain  [MAX_JOBS+1];

   logic                req_accept;
   logic                scan_last;
   logic                finish_go;
   logic                finish_hit;
   logic                do_load;
   logic                do_clear;
   logic                do_tick;
   logic                job_done;
   srtf_pkg::cand_type  best;
   logic [IDX_W-1:0]    best_idx;
   logic [15:0]         next_time;
   logic [15:0]         turn;
   logic [15:0]         wait_units;
   logic [CNT_W-1:0]    done_plus;
   srtf_pkg::job_type   load_job;

   assign req_accept = req_valid && !req_stall;
   assign do_load    = req_accept && (req_operation == srtf_pkg::OP_LOAD);
   assign do_tick    = req_accept && (req_operation == srtf_pkg::OP_TICK);
   assign do_clear   = req_accept && (req_operation == srtf_pkg::OP_CLEAR);
   assign scan_last  = (cnt_ff == IDX_W'(MAX_JOBS - 1));

   // Winner of the scan, as it leaves the last cell
   assign best     = cand_chain[MAX_JOBS];
   assign best_idx = idx_chain[MAX_JOBS];
   assign job_done = best.found && (best.remaining == 16'd1);

   // Hold a job-completing finish step while an older result waits on the rsp side
   assign finish_go  = (state_ff == srtf_pkg::ST_FINISH) &&
                       !(job_done && rsp_valid_ff && rsp_stall);
   assign finish_hit = finish_go && best.found;

   // Saturate time; results use the advanced value
   assign next_time  = (time_ff == srtf_pkg::TIME_MAX) ? time_ff : time_ff + 16'd1;
   assign turn       = next_time - best.arrival;
   assign wait_units = (turn >= best.burst) ? turn - best.burst : 16'd0;
   assign done_plus  = done_count_ff + CNT_W'(1);

   // Zero burst is stored as one unit
   always_comb begin
      load_job.id      = req_job_id;
      load_job.arrival = req_arrival_time;
      load_job.burst   = (req_burst_length == 16'd0) ? 16'd1 : req_burst_length;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         srtf_pkg::ST_IDLE: begin
            if (do_tick) begin
               state_in = srtf_pkg::ST_SCAN;
            end
         end
         srtf_pkg::ST_SCAN: begin
            if (scan_last) begin
               state_in = srtf_pkg::ST_FINISH;
            end
         end
         srtf_pkg::ST_FINISH: begin
            if (finish_go) begin
               state_in = srtf_pkg::ST_IDLE;
            end
         end
         default: state_in = srtf_pkg::ST_IDLE;
      endcase
   end

   // State machine outputs
   always_comb begin
      req_stall = 1'b1;
      cnt_in    = cnt_ff;
      case (state_ff)
         srtf_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cnt_in    = '0;
         end
         srtf_pkg::ST_SCAN: begin
            cnt_in = cnt_ff + IDX_W'(1);
         end
         srtf_pkg::ST_FINISH: begin
            cnt_in = '0;
         end
         default: begin
            req_stall = 1'b1;
            cnt_in    = '0;
         end
      endcase
   end

   // Counters and result handshake
   always_comb begin
      job_count_in  = job_count_ff;
      done_count_in = done_count_ff;
      time_in       = time_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      if (do_load && (job_count_ff < CNT_W'(MAX_JOBS))) begin
         job_count_in = job_count_ff + CNT_W'(1);
      end
      if (do_clear) begin
         job_count_in  = '0;
         done_count_in = '0;
      end
      if (finish_go) begin
         time_in = next_time;
         if (job_done) begin
            done_count_in = done_plus;
            rsp_valid_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= srtf_pkg::ST_IDLE;
         cnt_ff        <= '0;
         job_count_ff  <= '0;
         done_count_ff <= '0;
         time_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         job_count_ff  <= job_count_in;
         done_count_ff <= done_count_in;
         time_ff       <= time_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Capture the result of a finishing tick
   always_ff @(posedge clock) begin
      if (finish_go && job_done) begin
         rsp_id_ff         <= best.id;
         rsp_completion_ff <= next_time;
         rsp_turnaround_ff <= turn;
         rsp_waiting_ff    <= wait_units;
         rsp_all_done_ff   <= (done_plus == job_count_ff);
      end
   end

   // Feed an empty candidate into the head of the chain
   assign cand_chain[0] = '0;
   assign idx_chain[0]  = '0;

   for (genvar g = 0; g < MAX_JOBS; g++) begin : g_cell
      srtf_cell #(
         .IDX_W(IDX_W)
      ) u_cell (
         .clock    (clock),
         .slot_idx (IDX_W'(g)),
         .active   (CNT_W'(g) < job_count_ff),
         .cur_time (time_ff),
         .wr_en    (do_load && (job_count_ff == CNT_W'(g))),
         .wr_job   (load_job),
         .dec_en   (finish_hit && (best_idx == IDX_W'(g))),
         .cand_in  (cand_chain[g]),
         .idx_in   (idx_chain[g]),
         .cand_out (cand_chain[g+1]),
         .idx_out  (idx_chain[g+1])
      );
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_finished_id     = rsp_id_ff;
   assign rsp_completion_time = rsp_completion_ff;
   assign rsp_turnaround      = rsp_turnaround_ff;
   assign rsp_waiting         = rsp_waiting_ff;
   assign rsp_all_done        = rsp_all_done_ff;

`ifndef SYNTH
   a_done_le_jobs: assert property (@(posedge clock) disable iff (reset)
      done_count_ff <= job_count_ff)
      else $error("done count exceeds job count");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == srtf_pkg::ST_FINISH))
      else $error("result raised outside the finish step");

   a_time_frozen_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == srtf_pkg::ST_SCAN) |=> $stable(time_ff))
      else $error("time moved during a scan");

   a_tick_starts_scan: assert property (@(posedge clock) disable iff (reset)
      do_tick |=> (state_ff == srtf_pkg::ST_SCAN) && (cnt_ff == '0))
      else $error("tick did not start a scan");
`endif

endmodule

/* bench/tb_top.sv */
// Self-checking testbench for srtf_scheduler_core with its own scheduling predictor.
module tb_top;

   // Table size of the block and the cost of one tick through the slot chain.
   localparam int SLOTS         = 16;
   localparam int TICK_CYCLES   = SLOTS + 1;
   // Receiver hold-off used to fill the block and back up its input.
   localparam int HOLD_CYCLES   = 400;
   // Cycles without any transaction on either channel before giving up.
   localparam int STALL_LIMIT   = 2000;
   // Quiet time after the last completion, in case a late result shows up.
   localparam int SETTLE_CYCLES = 4 * TICK_CYCLES;
   // The block ignores the fourth operation code.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_operation = srtf_pkg::OP_LOAD;
   logic [7:0]  req_job_id = '0;
   logic [15:0] req_arrival_time = '0;
   logic [15:0] req_burst_length = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_finished_id;
   logic [15:0] rsp_completion_time;
   logic [15:0] rsp_turnaround;
   logic [15:0] rsp_waiting;
   logic        rsp_all_done;

   srtf_scheduler_core #(
      .MAX_JOBS(SLOTS)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_job_id         (req_job_id),
      .req_arrival_time   (req_arrival_time),
      .req_burst_length   (req_burst_length),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_finished_id    (rsp_finished_id),
      .rsp_completion_time(rsp_completion_time),
      .rsp_turnaround     (rsp_turnaround),
      .rsp_waiting        (rsp_waiting),
      .rsp_all_done       (rsp_all_done)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Scheduler predictor: a private copy of the job table, the counters and
   // the time base, advanced once per accepted request transaction.
   // ---------------------------------------------------------------------
   typedef struct {
      logic [7:0]  id;
      logic [15:0] completion;
      logic [15:0] turnaround;
      logic [15:0] waiting;
      logic        all_done;
   } completion_type;

   logic [7:0]  job_tag    [SLOTS];
   logic [15:0] job_arrive [SLOTS];
   logic [15:0] job_need   [SLOTS];
   logic [15:0] job_left   [SLOTS];
   bit          job_closed [SLOTS];
   int          jobs_loaded = 0;
   int          jobs_closed = 0;
   logic [15:0] sched_time = '0;

   // Completions the block still owes, oldest first.
   completion_type due_completions[$];

   int fault_count = 0;
   int items_sent  = 0;
   // Set by a test to run both sides without any idling.
   bit quiet_mode  = 1'b0;
   // Hold-off requests from the tests and the ones the receiver has served.
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;
   int idle_cycles   = 0;

   function automatic void advance_schedule(input logic [1:0] op, input logic [7:0] id,
                                            input logic [15:0] arrive,
                                            input logic [15:0] burst);
      int             pick;
      bit             found;
      logic [15:0]    turn;
      completion_type rec;
      case (op)
         srtf_pkg::OP_LOAD: begin
            // Drop the load once the table is full; a zero burst counts as one.
            if (jobs_loaded < SLOTS) begin
               job_tag[jobs_loaded]    = id;
               job_arrive[jobs_loaded] = arrive;
               job_need[jobs_loaded]   = (burst == 16'd0) ? 16'd1 : burst;
               job_left[jobs_loaded]   = job_need[jobs_loaded];
               job_closed[jobs_loaded] = 1'b0;
               jobs_loaded++;
            end
         end
         srtf_pkg::OP_TICK: begin
            // Pick the arrived, open job with the least remaining time; the
            // strict compare keeps the lowest slot on ties.
            found = 1'b0;
            pick  = 0;
            for (int slot = 0; slot < jobs_loaded; slot++) begin
               if (!job_closed[slot] && job_arrive[slot] <= sched_time &&
                   (!found || job_left[slot] < job_left[pick])) begin
                  pick  = slot;
                  found = 1'b1;
               end
            end
            // Advance time, holding it at the top of its range.
            if (sched_time != srtf_pkg::TIME_MAX)
               sched_time = sched_time + 16'd1;
            if (found) begin
               job_left[pick] = job_left[pick] - 16'd1;
               if (job_left[pick] == 16'd0) begin
                  job_closed[pick] = 1'b1;
                  jobs_closed++;
                  turn           = sched_time - job_arrive[pick];
                  rec.id         = job_tag[pick];
                  rec.completion = sched_time;
                  rec.turnaround = turn;
                  // Saturated time can leave turnaround below the burst.
                  rec.waiting    = (turn >= job_need[pick]) ? turn - job_need[pick] : 16'd0;
                  rec.all_done   = (jobs_closed == jobs_loaded);
                  due_completions.push_back(rec);
               end
            end
         end
         srtf_pkg::OP_CLEAR: begin
            // Empty the table but keep the time base.
            jobs_loaded = 0;
            jobs_closed = 0;
         end
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Request side: offer one transaction, hold it until accepted, then
   // advance the predictor with it.
   // ---------------------------------------------------------------------
   task automatic issue_request(input logic [1:0] op, input logic [7:0] id,
                                input logic [15:0] arrive, input logic [15:0] burst);
      int gap;
      // Idle now and then so gaps land in every phase of the block's work.
      if (!quiet_mode && $urandom_range(99) < 20) begin
         gap = $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_job_id       <= id;
      req_arrival_time <= arrive;
      req_burst_length <= burst;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      advance_schedule(op, id, arrive, burst);
      if (op != OP_UNUSED)
         items_sent++;
   endtask

   // Mostly short bursts so batches finish; a few full-range values and zeros.
   function automatic logic [15:0] pick_burst();
      int roll;
      roll = $urandom_range(99);
      if (roll < 3)
         return 16'd0;
      if (roll < 13)
         return 16'($urandom_range(65535));
      return 16'($urandom_range(1, 12));
   endfunction

   // Arrivals cluster just ahead of the current time; late batches cluster
   // near the top of the time range, so their jobs mostly stay waiting.
   function automatic logic [15:0] pick_arrival(input bit late);
      int roll;
      int soon;
      roll = $urandom_range(99);
      if (roll < 8)
         return 16'($urandom_range(65535));
      if (late)
         return 16'(srtf_pkg::TIME_MAX - $urandom_range(60));
      if (roll < 18)
         return 16'($urandom_range(sched_time));
      soon = sched_time + $urandom_range(30);
      return (soon > 65535) ? srtf_pkg::TIME_MAX : soon[15:0];
   endfunction

   // One well-formed batch: usually clear, load a set of jobs, then tick until
   // they are all done or the tick budget runs out. Sprinkle in ignored codes,
   // late loads and the odd clear as noise.
   task automatic run_batch(input bit late);
      int          loads;
      int          budget;
      int          ticks;
      int          roll;
      logic [15:0] burst;
      if ($urandom_range(99) < 85)
         issue_request(srtf_pkg::OP_CLEAR, 8'($urandom_range(255)),
                       16'($urandom_range(65535)), 16'($urandom_range(65535)));
      // Now and then overfill the table so loads get dropped.
      loads  = ($urandom_range(99) < 15) ? $urandom_range(17, 20) : $urandom_range(1, 12);
      budget = 40;
      repeat (loads) begin
         burst = pick_burst();
         if (burst <= 16'd12)
            budget += burst + 1;
         issue_request(srtf_pkg::OP_LOAD, 8'($urandom_range(255)), pick_arrival(late),
                       burst);
      end
      ticks = 0;
      while (jobs_closed != jobs_loaded && ticks < budget) begin
         roll = $urandom_range(99);
         if (roll < 4) begin
            issue_request(OP_UNUSED, 8'($urandom_range(255)),
                          16'($urandom_range(65535)), 16'($urandom_range(65535)));
         end else if (roll < 7) begin
            issue_request(srtf_pkg::OP_LOAD, 8'($urandom_range(255)), pick_arrival(late),
                          pick_burst());
         end else if (roll < 8) begin
            issue_request(srtf_pkg::OP_CLEAR, 8'($urandom_range(255)),
                          16'($urandom_range(65535)), 16'($urandom_range(65535)));
         end else begin
            issue_request(srtf_pkg::OP_TICK, 8'($urandom_range(255)),
                          16'($urandom_range(65535)), 16'($urandom_range(65535)));
            ticks++;
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Test tasks
   // ---------------------------------------------------------------------

   // Preemption, shortest-first choice and the lowest-slot tie break.
   task automatic test_basic_order();
      issue_request(srtf_pkg::OP_CLEAR, 8'h00, 16'h0000, 16'h0000);
      issue_request(srtf_pkg::OP_LOAD, 8'hFF, 16'd0, 16'd3);
      issue_request(srtf_pkg::OP_LOAD, 8'h00, 16'd1, 16'd1);
      issue_request(srtf_pkg::OP_LOAD, 8'hA5, 16'd0, 16'd3);
      repeat (7) issue_request(srtf_pkg::OP_TICK, 8'h00, 16'h0000, 16'h0000);
   endtask

   // Ignored code, idle tick, zero burst, and a job with top arrival and burst.
   task automatic test_corner_items();
      issue_request(srtf_pkg::OP_CLEAR, 8'hFF, 16'hFFFF, 16'hFFFF);
      issue_request(OP_UNUSED, 8'hFF, 16'hFFFF, 16'hFFFF);
      issue_request(srtf_pkg::OP_TICK, 8'hFF, 16'hFFFF, 16'hFFFF);
      issue_request(srtf_pkg::OP_LOAD, 8'h5A, 16'd0, 16'd0);
      issue_request(srtf_pkg::OP_LOAD, 8'hC3, 16'hFFFF, 16'hFFFF);
      repeat (2) issue_request(srtf_pkg::OP_TICK, 8'h00, 16'h0000, 16'h0000);
   endtask

   // Stall the result side for a long stretch while one-unit jobs finish on
   // every tick, so a result sits in the block and its input backs up.
   task automatic test_backpressure();
      quiet_mode = 1'b1;
      hold_requests++;
      issue_request(srtf_pkg::OP_CLEAR, 8'h00, 16'h0000, 16'h0000);
      for (int n = 0; n < 8; n++)
         issue_request(srtf_pkg::OP_LOAD, 8'($urandom_range(255)), 16'd0, 16'd1);
      repeat (8) issue_request(srtf_pkg::OP_TICK, 8'h00, 16'h0000, 16'h0000);
      quiet_mode = 1'b0;
   endtask

   task automatic test_random_batches(input int count, input bit late);
      int goal;
      goal = items_sent + count;
      while (items_sent < goal)
         run_batch(late);
   endtask

   // A long stretch with no idling on either side.
   task automatic test_back_to_back();
      quiet_mode = 1'b1;
      repeat (2) run_batch(1'b0);
      quiet_mode = 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Result side
   // ---------------------------------------------------------------------

   // Receiver: stall at random, or for a long counted stretch when asked.
   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served <= hold_served + 1;
         hold_left   <= HOLD_CYCLES;
         rsp_stall   <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !quiet_mode && ($urandom_range(99) < 20);
      end
   end

   task automatic compare_field(input string label, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
         fault_count++;
      end
   endtask

   // Check every accepted completion against the oldest one predicted.
   always @(posedge clock) begin
      completion_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (due_completions.size() == 0) begin
            $display("%0t: unexpected completion, expected none, actual id %0h time %0h",
                     $time, rsp_finished_id, rsp_completion_time);
            fault_count++;
         end else begin
            want = due_completions.pop_front();
            compare_field("finished_id", 16'(want.id), 16'(rsp_finished_id));
            compare_field("completion_time", want.completion, rsp_completion_time);
            compare_field("turnaround", want.turnaround, rsp_turnaround);
            compare_field("waiting", want.waiting, rsp_waiting);
            compare_field("all_done", 16'(want.all_done), 16'(rsp_all_done));
         end
      end
   end

   // Watchdog: end the run if neither channel moves for too long.
   always @(posedge clock) begin
      if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
         $display("srtf_scheduler_core test failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Sequence: reset once, run the tests in turn, drain, report.
   // ---------------------------------------------------------------------
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_order();
      test_corner_items();
      test_backpressure();
      test_random_batches(400, 1'b0);
      test_back_to_back();
      test_random_batches(250, 1'b1);

      req_valid <= 1'b0;
      // Wait for every owed completion, then a little longer for strays.
      while (due_completions.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (fault_count == 0) begin
         $display("srtf_scheduler_core test passed");
      end else begin
         $display("srtf_scheduler_core test failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/srtf_pkg.sv
rtl/srtf_cell.sv
rtl/srtf_scheduler_core.sv
bench/tb_top.sv
